/* rtl/gda_pkg.sv */
// Package for the Gregorian date counter: word types, codes and constants.
`default_nettype none
package gda_pkg;

  // Function codes of an input word
  localparam logic [1:0] FuncLoad     = 2'd0;
  localparam logic [1:0] FuncAddDays  = 2'd1;
  localparam logic [1:0] FuncAddWeeks = 2'd2;

  // Configuration register indexes
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgLimitYear  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLimitMonth = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgLimitDay   = 2'd2;

  localparam int unsigned StepW = 12;

  // Calendar constants
  localparam logic [3:0] MonFeb        = 4'd2;
  localparam logic [3:0] MonApr        = 4'd4;
  localparam logic [3:0] MonJun        = 4'd6;
  localparam logic [3:0] MonSep        = 4'd9;
  localparam logic [3:0] MonNov        = 4'd11;
  localparam logic [3:0] MonthsPerYear = 4'd12;
  localparam logic [2:0] LastWeekday   = 3'd6;
  localparam logic [6:0] LastYrMod100  = 7'd99;
  localparam logic [4:0] LenShort      = 5'd30;
  localparam logic [4:0] LenFebCommon  = 5'd28;
  localparam logic [4:0] LenFebLeap    = 5'd29;
  localparam logic [4:0] LenLong       = 5'd31;

  // year / 100 = (year >> 2) / 25; reciprocal exact for 14-bit dividends
  localparam int unsigned Div25Shift = 17;
  localparam logic [12:0] Div25Magic = 13'd5243;
  localparam logic [6:0]  Hundred    = 7'd100;

  // Reset values
  localparam logic [15:0] RstYear      = 16'd1900;
  localparam logic [3:0]  RstMonth     = 4'd1;
  localparam logic [4:0]  RstDay       = 5'd1;
  localparam logic [2:0]  RstWeekday   = 3'd1;
  localparam logic [6:0]  RstYrMod100  = 7'd0;
  localparam logic [1:0]  RstCentury   = 2'd3;
  localparam logic [15:0] RstLimYear   = 16'd2000;
  localparam logic [3:0]  RstLimMonth  = 4'd12;
  localparam logic [4:0]  RstLimDay    = 5'd31;

  typedef struct packed {
    logic [1:0]       func;
    logic [15:0]      load_year;
    logic [3:0]       load_month;
    logic [4:0]       load_day;
    logic [2:0]       load_weekday;
    logic [StepW-1:0] step_count;
  } in_t;

  typedef struct packed {
    logic [15:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [2:0]  cur_weekday;
    logic        before_limit;
    logic        year_wrapped;
  } out_t;

  // Held date plus year mod 100 and (year / 100) mod 4 for the leap rule
  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
    logic [6:0]  yr_mod100;
    logic [1:0]  century;
  } date_t;

endpackage
`default_nettype wire

/* rtl/gda_day_step.sv */
// One-day advance of the held date, shared across all day steps.
`default_nettype none
module gda_day_step (
  input  gda_pkg::date_t cur_i,
  output gda_pkg::date_t nxt_o,
  output logic           wrap_o
);
  import gda_pkg::*;

  logic       leap;
  logic [4:0] mlen;
  logic [5:0] day_inc;
  logic [4:0] month_inc;

  always_comb begin
    leap = (cur_i.yr_mod100 != 7'd0) ? (cur_i.year[1:0] == 2'd0)
                                     : (cur_i.century == 2'd0);
    case (cur_i.month)
      MonApr, MonJun, MonSep, MonNov: mlen = LenShort;
      MonFeb:                         mlen = leap ? LenFebLeap : LenFebCommon;
      default:                        mlen = LenLong;
    endcase

    nxt_o  = cur_i;
    wrap_o = 1'b0;
    nxt_o.weekday = (cur_i.weekday >= LastWeekday) ? 3'd0 : cur_i.weekday + 3'd1;

    day_inc   = {1'b0, cur_i.day} + 6'd1;
    month_inc = {1'b0, cur_i.month};
    if (day_inc > {1'b0, mlen}) begin
      nxt_o.day = 5'd1;
      month_inc = month_inc + 5'd1;
    end else begin
      nxt_o.day = day_inc[4:0];
    end

    if (month_inc > {1'b0, MonthsPerYear}) begin
      nxt_o.month = 4'd1;
      nxt_o.year  = cur_i.year + 16'd1;
      if (cur_i.year == 16'hFFFF) begin
        wrap_o          = 1'b1;
        nxt_o.yr_mod100 = 7'd0;
        nxt_o.century   = 2'd0;
      end else if (cur_i.yr_mod100 == LastYrMod100) begin
        nxt_o.yr_mod100 = 7'd0;
        nxt_o.century   = cur_i.century + 2'd1;
      end else begin
        nxt_o.yr_mod100 = cur_i.yr_mod100 + 7'd1;
      end
    end else begin
      nxt_o.month = month_inc[3:0];
    end
  end

endmodule
`default_nettype wire

/* rtl/gregorian_date_advance.sv */
// Top level of the Gregorian date counter: sequencer, config and output register.
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_stall_o  in_word_i  (gda_pkg::in_t)
//   out      output     out_valid_o/ out_stall_i out_word_o (gda_pkg::out_t)
//   cfg      input      cfg_we_i                 cfg_idx_i, cfg_data_i
//
// Add-days word steps step_count days; add-weeks word steps 7 * step_count days.
// Load word: two multiply steps split the year for the leap rule.
// One day per cycle through the shared day-step unit; in_stall_o is high
// until the result is in the output register. The result waits there while
// out_stall_i is high; the next word is taken meanwhile. Reset date is
// Monday 1900-01-01, limit 2000-12-31.
`default_nettype none
module gregorian_date_advance #(
  parameter int unsigned COUNT_WIDTH = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  gda_pkg::in_t                    in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output gda_pkg::out_t                   out_word_o,
  input  logic                            cfg_we_i,
  input  logic [gda_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [gda_pkg::CfgDataW-1:0]    cfg_data_i
);
  import gda_pkg::*;

  localparam int unsigned CntW  = (COUNT_WIDTH < StepW) ? COUNT_WIDTH : StepW;
  localparam int unsigned DaysW = CntW + 3;
  localparam int unsigned ProdW = 14 + 13;
  localparam int unsigned QuotW = 10;

  typedef enum logic [2:0] {StIdle, StSplit, StRem, StStep, StDone} state_e;

  state_e           state_q, state_d;
  date_t            date_q, date_d;
  logic [DaysW-1:0] days_q, days_d;
  logic             wrap_q, wrap_d;
  logic [QuotW-1:0] quot_q, quot_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_word_q, out_word_d;

  logic [15:0] lim_year_q;
  logic [3:0]  lim_month_q;
  logic [4:0]  lim_day_q;

  date_t            step_nxt;
  logic             step_wrap;
  logic [CntW-1:0]  cnt;
  logic [DaysW-1:0] days_in;
  logic [ProdW-1:0] split_prod;
  logic [16:0]      rem_full;
  logic             before_lim;

  gda_day_step u_step (
    .cur_i  (date_q),
    .nxt_o  (step_nxt),
    .wrap_o (step_wrap)
  );

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_comb begin
    cnt = in_word_i.step_count[CntW-1:0];
    case (in_word_i.func)
      FuncAddDays:  days_in = {3'b000, cnt};
      FuncAddWeeks: days_in = {cnt, 3'b000} - {3'b000, cnt};
      default:      days_in = '0;
    endcase

    split_prod = ProdW'(date_q.year[15:2]) * ProdW'(Div25Magic);
    rem_full   = {1'b0, date_q.year} - 17'(quot_q) * 17'(Hundred);

    if (date_q.year != lim_year_q) begin
      before_lim = date_q.year < lim_year_q;
    end else if (date_q.month != lim_month_q) begin
      before_lim = date_q.month < lim_month_q;
    end else begin
      before_lim = date_q.day < lim_day_q;
    end

    state_d     = state_q;
    date_d      = date_q;
    days_d      = days_q;
    wrap_d      = wrap_q;
    quot_d      = quot_q;
    out_word_d  = out_word_q;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          wrap_d = 1'b0;
          case (in_word_i.func)
            FuncLoad: begin
              date_d.year    = in_word_i.load_year;
              date_d.month   = in_word_i.load_month;
              date_d.day     = in_word_i.load_day;
              date_d.weekday = in_word_i.load_weekday;
              state_d        = StSplit;
            end
            FuncAddDays, FuncAddWeeks: begin
              days_d  = days_in;
              state_d = (days_in == '0) ? StDone : StStep;
            end
            default: state_d = StDone;
          endcase
        end
      end
      StSplit: begin
        quot_d  = split_prod[Div25Shift +: QuotW];
        state_d = StRem;
      end
      StRem: begin
        date_d.yr_mod100 = rem_full[6:0];
        date_d.century   = quot_q[1:0];
        state_d          = StDone;
      end
      StStep: begin
        date_d = step_nxt;
        wrap_d = wrap_q | step_wrap;
        days_d = days_q - DaysW'(1);
        if (days_q == DaysW'(1)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || !out_stall_i) begin
          out_word_d.cur_year     = date_q.year;
          out_word_d.cur_month    = date_q.month;
          out_word_d.cur_day      = date_q.day;
          out_word_d.cur_weekday  = date_q.weekday;
          out_word_d.before_limit = before_lim;
          out_word_d.year_wrapped = wrap_q;
          out_valid_d             = 1'b1;
          state_d                 = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= StIdle;
      date_q.year       <= RstYear;
      date_q.month      <= RstMonth;
      date_q.day        <= RstDay;
      date_q.weekday    <= RstWeekday;
      date_q.yr_mod100  <= RstYrMod100;
      date_q.century    <= RstCentury;
      days_q            <= '0;
      wrap_q            <= 1'b0;
      quot_q            <= '0;
      out_valid_q       <= 1'b0;
      out_word_q        <= '0;
    end else begin
      state_q     <= state_d;
      date_q      <= date_d;
      days_q      <= days_d;
      wrap_q      <= wrap_d;
      quot_q      <= quot_d;
      out_valid_q <= out_valid_d;
      out_word_q  <= out_word_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_year_q  <= RstLimYear;
      lim_month_q <= RstLimMonth;
      lim_day_q   <= RstLimDay;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLimitYear:  lim_year_q  <= cfg_data_i;
        CfgLimitMonth: lim_month_q <= cfg_data_i[3:0];
        CfgLimitDay:   lim_day_q   <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* tb/gregorian_date_advance_test.sv */
// Self-checking testbench for the Gregorian date counter with a scoreboard class.
`timescale 1ns / 100ps
module gregorian_date_advance_test;
  import gda_pkg::*;

  localparam logic [1:0] FuncUnused = 2'd3;

  class date_checker;
    logic [15:0] lim_year;
    logic [3:0]  lim_month;
    logic [4:0]  lim_day;
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
    out_t        expected_dates[$];
    int          errors;

    function new();
      lim_year  = 16'd2000;
      lim_month = 4'd12;
      lim_day   = 5'd31;
      year      = 16'd1900;
      month     = 4'd1;
      day       = 5'd1;
      weekday   = 3'd1;
      errors    = 0;
    endfunction

    function void set_limits(logic [15:0] y, logic [3:0] m, logic [4:0] d);
      lim_year  = y;
      lim_month = m;
      lim_day   = d;
    endfunction

    function bit is_leap(int unsigned y);
      if (y % 100 != 0) return (y % 4) == 0;
      return (y % 400) == 0;
    endfunction

    function int unsigned month_days(int unsigned m, int unsigned y);
      if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
      if (m == 2) return is_leap(y) ? 29 : 28;
      return 31;
    endfunction

    // one day step; returns 1 when the year wraps to 0
    function bit advance_one_day();
      int unsigned d;
      int unsigned m;
      bit          wrapped;
      wrapped = 1'b0;
      d = day + 1;
      m = month;
      weekday = (weekday >= 3'd6) ? 3'd0 : weekday + 3'd1;
      if (d > month_days(m, year)) begin
        d = 1;
        m = m + 1;
      end
      if (m > 12) begin
        m = 1;
        if (year == 16'hFFFF) wrapped = 1'b1;
        year = year + 16'd1;
      end
      day   = d[4:0];
      month = m[3:0];
      return wrapped;
    endfunction

    function bit date_before_limit();
      if (year != lim_year) return year < lim_year;
      if (month != lim_month) return month < lim_month;
      return day < lim_day;
    endfunction

    function void note_word(in_t w);
      int unsigned n;
      bit          wrapped;
      out_t        r;
      n = 0;
      wrapped = 1'b0;
      case (w.func)
        FuncLoad: begin
          year    = w.load_year;
          month   = w.load_month;
          day     = w.load_day;
          weekday = w.load_weekday;
        end
        FuncAddDays:  n = w.step_count;
        FuncAddWeeks: n = 7 * w.step_count;
        default: ;
      endcase
      repeat (n) begin
        if (advance_one_day()) wrapped = 1'b1;
      end
      r.cur_year     = year;
      r.cur_month    = month;
      r.cur_day      = day;
      r.cur_weekday  = weekday;
      r.before_limit = date_before_limit();
      r.year_wrapped = wrapped;
      expected_dates.push_back(r);
    endfunction

    function void check_word(out_t got);
      out_t want;
      if (expected_dates.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: %0d-%0d-%0d wd %0d before %0b wrap %0b",
                   got.cur_year, got.cur_month, got.cur_day, got.cur_weekday,
                   got.before_limit, got.year_wrapped);
        return;
      end
      want = expected_dates.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: exp %0d-%0d-%0d wd %0d before %0b wrap %0b, ",
                    "got %0d-%0d-%0d wd %0d before %0b wrap %0b"},
                   want.cur_year, want.cur_month, want.cur_day, want.cur_weekday,
                   want.before_limit, want.year_wrapped,
                   got.cur_year, got.cur_month, got.cur_day, got.cur_weekday,
                   got.before_limit, got.year_wrapped);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_t                 in_word_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_t                out_word_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = CfgLimitYear;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  date_checker sb;
  int          send_pct = 25;
  int          recv_pct = 81;

  gregorian_date_advance dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_pct);
  end

  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) sb.note_word(in_word_i);
    if (out_valid_o && !out_stall_i) sb.check_word(out_word_o);
  end

  task automatic send_word(input in_t w);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic in_t random_word();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_t)-1:0];
  endfunction

  task automatic send_load(input logic [15:0] y, input logic [3:0] m,
                           input logic [4:0] d, input logic [2:0] wd);
    in_t w;
    w = random_word();
    w.func         = FuncLoad;
    w.load_year    = y;
    w.load_month   = m;
    w.load_day     = d;
    w.load_weekday = wd;
    send_word(w);
  endtask

  task automatic send_step(input logic [1:0] f, input logic [StepW-1:0] n);
    in_t w;
    w = random_word();
    w.func       = f;
    w.step_count = n;
    send_word(w);
  endtask

  // input side goes quiet, all results drained
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_dates.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limits(input logic [15:0] y, input logic [3:0] m,
                              input logic [4:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgLimitYear;
    cfg_data_i <= y;
    @(posedge clk_i);
    cfg_idx_i  <= CfgLimitMonth;
    cfg_data_i <= 16'(m);
    @(posedge clk_i);
    cfg_idx_i  <= CfgLimitDay;
    cfg_data_i <= 16'(d);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_limits(y, m, d);
  endtask

  function automatic logic [15:0] pick_year();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'(100 * $urandom_range(0, 655));
      2:       return 16'(400 * $urandom_range(0, 163));
      3:       return 16'(65535 - $urandom_range(0, 3));
      4:       return 16'($urandom_range(0, 3));
      default: return 16'($urandom_range(1880, 2120));
    endcase
  endfunction

  function automatic in_t make_word();
    in_t         w;
    int unsigned r;
    int unsigned len;
    w = random_word();
    r = $urandom_range(0, 99);
    if (r < 14) begin
      w.func         = FuncLoad;
      w.load_year    = pick_year();
      w.load_month   = 4'($urandom_range(1, 12));
      len            = sb.month_days(w.load_month, w.load_year);
      w.load_day     = $urandom_range(0, 1) ? 5'(len - $urandom_range(0, 2))
                                            : 5'($urandom_range(1, len));
      w.load_weekday = 3'($urandom_range(0, 6));
    end else if (r < 19) begin
      w.func = FuncLoad;
    end else if (r < 22) begin
      w.func = FuncUnused;
    end else if (r < 24) begin
      w.func       = FuncLoad;
      w.load_year  = 16'hFFFF;
      w.load_month = 4'd12;
      w.load_day   = 5'($urandom_range(20, 31));
    end else if (r < 62) begin
      w.func       = FuncAddDays;
      w.step_count = ($urandom_range(0, 49) == 0) ? StepW'($urandom_range(0, 4095))
                                                 : StepW'($urandom_range(0, 70));
    end else begin
      w.func       = FuncAddWeeks;
      w.step_count = ($urandom_range(0, 199) == 0) ? StepW'($urandom_range(0, 4095))
                                                  : StepW'($urandom_range(0, 8));
    end
    return w;
  endfunction

  task automatic run_directed();
    send_step(FuncAddDays, StepW'(0));
    send_step(FuncUnused, StepW'($urandom_range(0, 4095)));
    // 1900 is not leap, 2000 is
    send_load(16'd1900, 4'd2, 5'd28, 3'd3);
    send_step(FuncAddDays, StepW'(1));
    send_load(16'd2000, 4'd2, 5'd28, 3'd1);
    send_step(FuncAddDays, StepW'(1));
    send_step(FuncAddDays, StepW'(1));
    send_load(16'd2023, 4'd12, 5'd31, 3'd0);
    send_step(FuncAddDays, StepW'(1));
    // year wrap, then the longest steps
    send_load(16'hFFFF, 4'd12, 5'd31, 3'd6);
    send_step(FuncAddDays, StepW'(1));
    send_step(FuncAddWeeks, '1);
    send_step(FuncAddDays, '1);
    // bad months, bad days, weekday 7
    send_load(16'd1999, 4'd0, 5'd31, 3'd2);
    send_step(FuncAddDays, StepW'(1));
    send_load(16'd1999, 4'd13, 5'd5, 3'd2);
    send_step(FuncAddDays, StepW'(1));
    send_load(16'hFFFF, 4'd15, 5'd31, 3'd7);
    send_step(FuncAddDays, StepW'(1));
    send_load(16'd2001, 4'd4, 5'd31, 3'd4);
    send_step(FuncAddDays, StepW'(1));
    send_load(16'd2001, 4'd2, 5'd0, 3'd7);
    send_step(FuncAddWeeks, StepW'(1));
    // on and just below the limit date
    send_load(16'd2000, 4'd12, 5'd31, 3'd0);
    send_load(16'd2000, 4'd12, 5'd30, 3'd6);
    send_load(16'd0, 4'd0, 5'd0, 3'd0);
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    settle();
    for (int ph = 0; ph < 3; ph++) begin
      send_pct = (ph == 0) ? 25 : (ph == 1) ? 81 : 0;
      recv_pct = (ph == 0) ? 81 : (ph == 1) ? 25 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        if (ph == 0 && seg == 0)
          write_limits(16'd0, 4'd1, 5'd1);
        else if (ph == 0 && seg == 1)
          write_limits(16'hFFFF, 4'd12, 5'd31);
        else
          write_limits(($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                   : 16'($urandom_range(1890, 2110)),
                       4'($urandom_range(1, 12)), 5'($urandom_range(1, 31)));
        repeat (160) send_word(make_word());
        settle();
      end
    end
    repeat (50) @(posedge clk_i);
    if (sb.expected_dates.size() != 0) begin
      sb.errors++;
      $display("%0d expected words never arrived", sb.expected_dates.size());
    end
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
